FILE: rtl/sscr_pkg.sv
package sscr_pkg;

  // Default ring depth in frames.
  localparam int CAPACITY_DEF = 4096;

  // Fixed field widths of the channels.
  localparam int SAMPLE_W = 18;
  localparam int SNAP_W   = 13;
  localparam int INDEX_W  = 12;
  localparam int POS_W    = 48;
  localparam int WINDOW_W = 32;

  // Request codes.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // Full scale in Q2.16 and its negative.
  localparam logic signed [SAMPLE_W-1:0] FULL_SCALE_POS = 18'sd65536;
  localparam logic signed [SAMPLE_W-1:0] FULL_SCALE_NEG = -18'sd65536;

  // Entries in the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // One classified beat, as the front part hands it to the back part.
  typedef struct packed {
    logic                       is_read;
    logic                       clip;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic [SNAP_W-1:0]          snap_frames;
    logic [INDEX_W-1:0]         snap_index;
  } op_t;

endpackage

FILE: rtl/sscr_ram.sv
module sscr_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/sscr_front.sv
module sscr_front (
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                req_type,
  input  logic signed [sscr_pkg::SAMPLE_W-1:0] left_in,
  input  logic signed [sscr_pkg::SAMPLE_W-1:0] right_in,
  input  logic [sscr_pkg::SNAP_W-1:0]         snap_frames,
  input  logic [sscr_pkg::INDEX_W-1:0]        snap_index,
  input  logic                                q_full,
  output logic                                push,
  output sscr_pkg::op_t                       op
);

  logic l_clip;
  logic r_clip;
  logic signed [sscr_pkg::SAMPLE_W-1:0] l_clamp;
  logic signed [sscr_pkg::SAMPLE_W-1:0] r_clamp;

  // A sample at or beyond full scale in either direction counts as a clip.
  assign l_clip = (left_in >= sscr_pkg::FULL_SCALE_POS) || (left_in <= sscr_pkg::FULL_SCALE_NEG);
  assign r_clip = (right_in >= sscr_pkg::FULL_SCALE_POS) ||
                  (right_in <= sscr_pkg::FULL_SCALE_NEG);

  always_comb begin
    if (left_in > sscr_pkg::FULL_SCALE_POS) begin
      l_clamp = sscr_pkg::FULL_SCALE_POS;
    end else if (left_in < sscr_pkg::FULL_SCALE_NEG) begin
      l_clamp = sscr_pkg::FULL_SCALE_NEG;
    end else begin
      l_clamp = left_in;
    end
    if (right_in > sscr_pkg::FULL_SCALE_POS) begin
      r_clamp = sscr_pkg::FULL_SCALE_POS;
    end else if (right_in < sscr_pkg::FULL_SCALE_NEG) begin
      r_clamp = sscr_pkg::FULL_SCALE_NEG;
    end else begin
      r_clamp = right_in;
    end
  end

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    op.is_read     = (req_type == sscr_pkg::REQ_READ);
    op.clip        = (req_type == sscr_pkg::REQ_WRITE) && (l_clip || r_clip);
    op.left        = l_clamp;
    op.right       = r_clamp;
    op.snap_frames = snap_frames;
    op.snap_index  = snap_index;
  end

endmodule

FILE: rtl/sscr_queue.sv
module sscr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sscr_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output sscr_pkg::op_t head_op
);

  localparam int PW = (sscr_pkg::QUEUE_DEPTH > 1) ? $clog2(sscr_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(sscr_pkg::QUEUE_DEPTH + 1);

  sscr_pkg::op_t entries [sscr_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [PW-1:0] wr_ptr_next;
  logic [PW-1:0] rd_ptr_next;

  assign full    = (count == CW'(sscr_pkg::QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign head_op = entries[rd_ptr];

  assign wr_ptr_next = (wr_ptr == PW'(sscr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_next = (rd_ptr == PW'(sscr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr_next;
      end
      if (pop) begin
        rd_ptr <= rd_ptr_next;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/sscr_back.sv
module sscr_back #(
  parameter int CAPACITY = sscr_pkg::CAPACITY_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_valid,
  input  sscr_pkg::op_t                        head_op,
  output logic                                 pop,
  input  logic                                 clip_window_we,
  input  logic [sscr_pkg::WINDOW_W-1:0]        clip_window_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [sscr_pkg::SAMPLE_W-1:0] left_out,
  output logic signed [sscr_pkg::SAMPLE_W-1:0] right_out,
  output logic                                 read_valid,
  output logic [sscr_pkg::SNAP_W-1:0]          snap_count,
  output logic [sscr_pkg::POS_W-1:0]           frames_total,
  output logic                                 clip_recent
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = (CW > sscr_pkg::SNAP_W) ? CW : sscr_pkg::SNAP_W;
  localparam int EW = MW + 1;
  localparam int PW = sscr_pkg::POS_W;
  localparam int WW = sscr_pkg::WINDOW_W;

  // Ring state.
  logic [PW-1:0] write_count;
  logic [AW-1:0] wr_slot;
  logic [CW-1:0] fill;
  logic [PW-1:0] since_clip;
  logic          ever_clipped;
  logic [WW-1:0] clip_window;

  logic exec;
  logic do_write;
  logic do_read;
  logic wrap;

  logic [MW-1:0]              req_ext;
  logic [MW-1:0]              avail_ext;
  logic [MW-1:0]              cnt_ext;
  logic [sscr_pkg::SNAP_W-1:0] cnt;
  logic                       idx_ok;
  logic [sscr_pkg::SNAP_W-1:0] span;
  logic [EW-1:0]              slot_ext;
  logic [EW-1:0]              span_ext;
  logic [EW-1:0]              rd_slot_ext;
  logic [AW-1:0]              rd_slot;

  logic [sscr_pkg::SAMPLE_W-1:0] l_rdata;
  logic [sscr_pkg::SAMPLE_W-1:0] r_rdata;

  // The output stage advances when it is empty or being taken.
  assign exec     = q_valid && (!out_valid || out_ready);
  assign pop      = exec;
  assign do_write = exec && !head_op.is_read;
  assign wrap     = (write_count == {PW{1'b1}});

  // Snapshot length and the ring slot of the requested element.
  assign req_ext   = MW'(head_op.snap_frames);
  assign avail_ext = MW'(fill);
  assign cnt_ext   = (req_ext < avail_ext) ? req_ext : avail_ext;
  assign cnt       = cnt_ext[sscr_pkg::SNAP_W-1:0];
  assign idx_ok    = (sscr_pkg::SNAP_W'(head_op.snap_index) < cnt);
  assign span      = cnt - sscr_pkg::SNAP_W'(head_op.snap_index);
  assign slot_ext  = EW'(wr_slot);
  assign span_ext  = EW'(span);
  assign rd_slot_ext = (slot_ext >= span_ext) ? (slot_ext - span_ext)
                                              : (slot_ext + EW'(CAPACITY) - span_ext);
  assign rd_slot   = rd_slot_ext[AW-1:0];
  assign do_read   = exec && head_op.is_read && idx_ok;

  sscr_ram #(
    .WIDTH(sscr_pkg::SAMPLE_W),
    .DEPTH(CAPACITY)
  ) u_left_ram (
    .clk  (clk),
    .we   (do_write),
    .waddr(wr_slot),
    .wdata(head_op.left),
    .re   (do_read),
    .raddr(rd_slot),
    .rdata(l_rdata)
  );

  sscr_ram #(
    .WIDTH(sscr_pkg::SAMPLE_W),
    .DEPTH(CAPACITY)
  ) u_right_ram (
    .clk  (clk),
    .we   (do_write),
    .waddr(wr_slot),
    .wdata(head_op.right),
    .re   (do_read),
    .raddr(rd_slot),
    .rdata(r_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      write_count  <= '0;
      wr_slot      <= '0;
      fill         <= '0;
      since_clip   <= '0;
      ever_clipped <= 1'b0;
    end else if (do_write) begin
      write_count <= write_count + 1'b1;
      if (wrap || (wr_slot == AW'(CAPACITY - 1))) begin
        wr_slot <= '0;
      end else begin
        wr_slot <= wr_slot + 1'b1;
      end
      if (wrap) begin
        fill <= '0;
      end else if (fill != CW'(CAPACITY)) begin
        fill <= fill + 1'b1;
      end
      if (head_op.clip) begin
        since_clip   <= PW'(1);
        ever_clipped <= 1'b1;
      end else begin
        since_clip <= since_clip + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_window <= '0;
    end else if (clip_window_we) begin
      clip_window <= clip_window_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      read_valid <= head_op.is_read && idx_ok;
      snap_count <= head_op.is_read ? cnt : '0;
    end
  end

  // Samples come straight from the registered memory read.
  assign left_out  = read_valid ? $signed(l_rdata) : '0;
  assign right_out = read_valid ? $signed(r_rdata) : '0;

  // The ring state only moves when a new result is loaded, so frames_total always
  // describes the result on show; clip_recent also follows clip_window writes.
  assign frames_total = write_count;
  assign clip_recent  = ever_clipped && (since_clip[PW-1:WW] == '0) &&
                        (since_clip[WW-1:0] <= clip_window);

endmodule

FILE: rtl/stereo_scope_capture_ring.sv
// Capture ring for stereo audio frames in Q2.16 format.
//
// Every input beat is either a frame write (req_type low) or a read of one
// element of a snapshot of the newest frames (req_type high). Each input beat
// produces exactly one output beat, in order, on a valid/ready channel.
// Writes clamp both samples to full scale, store them in the ring and flag a
// clip when either magnitude reaches full scale. Reads return the element
// snap_index of the newest min(snap_frames, stored) frames, oldest first.
// Every output beat carries the frame count and the recent-clip indication.
//
// An input beat is classified in the front part and placed in a two-entry
// queue; the back part executes one beat per cycle against the ring memory
// while the receiver does not stall. An accepted beat waits in the queue and
// is loaded into the output register when the output stage advances. At most
// one beat per cycle passes, set by the single access per beat on the memory
// ports. When the receiver stalls, the output register holds its beat, the
// queue fills and in_ready falls once the queue holds two beats.
// Reset clears the counters, the clip history and clip_window; the ring
// memory is not cleared and no clearing pass is needed, since only written
// entries can be read.
module stereo_scope_capture_ring #(
  parameter int CAPACITY = sscr_pkg::CAPACITY_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 req_type,
  input  logic signed [sscr_pkg::SAMPLE_W-1:0] left_in,
  input  logic signed [sscr_pkg::SAMPLE_W-1:0] right_in,
  input  logic [sscr_pkg::SNAP_W-1:0]          snap_frames,
  input  logic [sscr_pkg::INDEX_W-1:0]         snap_index,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [sscr_pkg::SAMPLE_W-1:0] left_out,
  output logic signed [sscr_pkg::SAMPLE_W-1:0] right_out,
  output logic                                 read_valid,
  output logic [sscr_pkg::SNAP_W-1:0]          snap_count,
  output logic [sscr_pkg::POS_W-1:0]           frames_total,
  output logic                                 clip_recent,
  input  logic                                 clip_window_we,
  input  logic [sscr_pkg::WINDOW_W-1:0]        clip_window_data
);

  // Between the front part and the queue.
  logic          push;
  logic          q_full;
  sscr_pkg::op_t push_op;

  // Between the queue and the back part.
  logic          pop;
  logic          q_valid;
  sscr_pkg::op_t head_op;

  // The front part clamps the samples and detects clips as the beat arrives.
  sscr_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .left_in    (left_in),
    .right_in   (right_in),
    .snap_frames(snap_frames),
    .snap_index (snap_index),
    .q_full     (q_full),
    .push       (push),
    .op         (push_op)
  );

  // The queue decouples input acceptance from output stalls.
  sscr_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .push_op(push_op),
    .full   (q_full),
    .pop    (pop),
    .q_valid(q_valid),
    .head_op(head_op)
  );

  // The back part owns the ring memory, the counters and the output register.
  sscr_back #(
    .CAPACITY(CAPACITY)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .head_op         (head_op),
    .pop             (pop),
    .clip_window_we  (clip_window_we),
    .clip_window_data(clip_window_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .left_out        (left_out),
    .right_out       (right_out),
    .read_valid      (read_valid),
    .snap_count      (snap_count),
    .frames_total    (frames_total),
    .clip_recent     (clip_recent)
  );

endmodule
